// ===== hw/rtl/palette_index_builder_unit_defines.svh =====
// Shared assertion macros for the palette index builder
`ifndef PALETTE_INDEX_BUILDER_UNIT_DEFINES_SVH
`define PALETTE_INDEX_BUILDER_UNIT_DEFINES_SVH

// Check in the same cycle
`define PIB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pib assertion failed");

// Check in the following cycle
`define PIB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pib assertion failed");

`endif

// ===== hw/rtl/pib_pkg.sv =====
package pib_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ColorW = 3 * ChanW;
  localparam int unsigned CountW = 8;

  localparam logic [CountW-1:0] CodeOffset = 8'd32;
  localparam logic [CountW-1:0] CodeFull   = 8'd0;

  localparam logic [1:0] StatusFound = 2'd0;
  localparam logic [1:0] StatusAdded = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } pib_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } pib_stat_t;

endpackage

// ===== hw/rtl/pib_pixel_if.sv =====
interface pib_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [pib_pkg::ChanW-1:0]  red;
  logic [pib_pkg::ChanW-1:0]  green;
  logic [pib_pkg::ChanW-1:0]  blue;
  logic                       frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

// ===== hw/rtl/pib_code_if.sv =====
interface pib_code_if;
  logic                        valid;
  logic                        ready;
  logic [pib_pkg::CountW-1:0]  pixel_code;
  logic [1:0]                  status;
  logic [pib_pkg::CountW-1:0]  color_count;
  logic                        overflow_seen;

  modport source (output valid, pixel_code, status, color_count, overflow_seen,
                  input ready);
  modport sink   (input valid, pixel_code, status, color_count, overflow_seen,
                  output ready);
endinterface

// ===== hw/rtl/pib_ram.sv =====
module pib_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 224,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/pib_ctrl.sv =====
module pib_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pib_pkg::pib_stat_t stat_i,
  output pib_pkg::pib_cmd_t  cmd_o
);
  typedef enum logic [1:0] {
    StIdle   = 2'b01,
    StSearch = 2'b10
  } pib_state_e;

  pib_state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StSearch;
        end
      end
      StSearch: begin
        if (!stat_i.done) begin
          cmd_o.step = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== hw/rtl/pib_datapath.sv =====
module pib_datapath #(
  parameter int unsigned MAX_COLORS = 224
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pib_pkg::pib_cmd_t           cmd_i,
  output pib_pkg::pib_stat_t          stat_o,
  input  logic [pib_pkg::ChanW-1:0]   red_i,
  input  logic [pib_pkg::ChanW-1:0]   green_i,
  input  logic [pib_pkg::ChanW-1:0]   blue_i,
  input  logic                        frame_start_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [pib_pkg::CountW-1:0]  pixel_code_o,
  output logic [1:0]                  status_o,
  output logic [pib_pkg::CountW-1:0]  color_count_o,
  output logic                        overflow_seen_o
);
  localparam int unsigned AddrW  = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int unsigned CountW = pib_pkg::CountW;
  localparam int unsigned ColorW = pib_pkg::ColorW;
  localparam logic [CountW-1:0] MaxCnt = CountW'(MAX_COLORS);

  logic [ColorW-1:0] color_q, color_d;
  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [CountW-1:0] cmp_idx_q, cmp_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] code_q, code_d;
  logic [1:0]        status_q, status_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic              out_ovf_q, out_ovf_d;

  logic [ColorW-1:0] rdata;
  logic              addr_ok, hit, scan_end, room, ram_re, ram_we;

  pib_ram #(
    .Width (ColorW),
    .Depth (MAX_COLORS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (color_q),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    addr_ok  = idx_q < count_q;
    hit      = cmp_vld_q && (rdata == color_q);
    scan_end = !cmp_vld_q && !addr_ok;
    room     = count_q < MaxCnt;
    ram_re   = cmd_i.step && addr_ok;
    ram_we   = cmd_i.commit && !hit && room;

    stat_o.done     = hit || scan_end;
    stat_o.out_free = !out_valid_q || out_ready_i;

    color_d     = color_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    status_d    = status_q;
    out_count_d = out_count_q;
    out_ovf_d   = out_ovf_q;

    if (cmd_i.start) begin
      color_d   = {red_i, green_i, blue_i};
      idx_d     = '0;
      cmp_vld_d = 1'b0;
      if (frame_start_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end

    if (cmd_i.step) begin
      cmp_vld_d = addr_ok;
      cmp_idx_d = idx_q;
      if (addr_ok) begin
        idx_d = idx_q + CountW'(1);
      end
    end

    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      if (hit) begin
        code_d   = cmp_idx_q + pib_pkg::CodeOffset;
        status_d = pib_pkg::StatusFound;
      end else if (room) begin
        code_d   = count_q + pib_pkg::CodeOffset;
        status_d = pib_pkg::StatusAdded;
        count_d  = count_q + CountW'(1);
      end else begin
        code_d   = pib_pkg::CodeFull;
        status_d = pib_pkg::StatusFull;
        ovf_d    = 1'b1;
      end
      out_count_d = count_d;
      out_ovf_d   = ovf_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q     <= color_d;
    cmp_idx_q   <= cmp_idx_d;
    code_q      <= code_d;
    status_q    <= status_d;
    out_count_q <= out_count_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_code_o    = code_q;
  assign status_o        = status_q;
  assign color_count_o   = out_count_q;
  assign overflow_seen_o = out_ovf_q;
endmodule

// ===== hw/rtl/palette_index_builder_unit.sv =====
// A pixel is accepted only while idle; the colour RAM is then scanned one entry
// per cycle, up to MAX_COLORS entries, until a match or the last stored entry,
// and the code beat is committed to the output register, which a held output
// beat stalls. The next pixel is not accepted until the last one is committed.
// Reset clears the entry count, the overflow flag and the output valid; the
// colour RAM is not cleared, since only entries below the count are ever read.
module palette_index_builder_unit #(
  parameter int unsigned MAX_COLORS = 224
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pib_pixel_if.sink   pixel_i,
  pib_code_if.source  code_o
);
  pib_pkg::pib_cmd_t  cmd;
  pib_pkg::pib_stat_t stat;

  pib_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pixel_i.valid),
    .in_ready_o (pixel_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pib_datapath #(
    .MAX_COLORS (MAX_COLORS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .red_i           (pixel_i.red),
    .green_i         (pixel_i.green),
    .blue_i          (pixel_i.blue),
    .frame_start_i   (pixel_i.frame_start),
    .out_ready_i     (code_o.ready),
    .out_valid_o     (code_o.valid),
    .pixel_code_o    (code_o.pixel_code),
    .status_o        (code_o.status),
    .color_count_o   (code_o.color_count),
    .overflow_seen_o (code_o.overflow_seen)
  );
endmodule

// ===== hw/rtl/pib_checker.sv =====
`include "palette_index_builder_unit_defines.svh"

module pib_checker #(
  parameter int unsigned MAX_COLORS = 224
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [pib_pkg::CountW-1:0]  pixel_code_i,
  input logic [1:0]                  status_i,
  input logic [pib_pkg::CountW-1:0]  color_count_i,
  input logic                        overflow_seen_i
);
  localparam logic [pib_pkg::CountW-1:0] MaxCnt = pib_pkg::CountW'(MAX_COLORS);

  `PIB_ASSERT_NOW(a_full_beat, out_valid_i && (status_i == pib_pkg::StatusFull),
    (pixel_code_i == pib_pkg::CodeFull) && overflow_seen_i && (color_count_i == MaxCnt))
  `PIB_ASSERT_NOW(a_added_last, out_valid_i && (status_i == pib_pkg::StatusAdded),
    pixel_code_i == (color_count_i + pib_pkg::CodeOffset - pib_pkg::CountW'(1)))
  `PIB_ASSERT_NOW(a_found_range, out_valid_i && (status_i == pib_pkg::StatusFound),
    (pixel_code_i >= pib_pkg::CodeOffset)
    && ((pixel_code_i - pib_pkg::CodeOffset) < color_count_i))
  `PIB_ASSERT_NEXT(a_hold_beat, out_valid_i && !out_ready_i,
    out_valid_i && $stable(pixel_code_i) && $stable(status_i) && $stable(color_count_i))
endmodule

bind palette_index_builder_unit pib_checker #(
  .MAX_COLORS (MAX_COLORS)
) u_pib_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (code_o.valid),
  .out_ready_i     (code_o.ready),
  .pixel_code_i    (code_o.pixel_code),
  .status_i        (code_o.status),
  .color_count_i   (code_o.color_count),
  .overflow_seen_i (code_o.overflow_seen)
);

// ===== verif/tb_palette_index_builder_unit.sv =====
`timescale 1ns / 1ps

module tb_palette_index_builder_unit;

  localparam int unsigned MaxColors = 224;
  localparam int unsigned MaxGap    = 11;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = MaxColors + 16;
  localparam int unsigned ItemTarget = 1600;

  typedef struct packed {
    logic [pib_pkg::CountW-1:0] pixel_code;
    logic [1:0]                 status;
    logic [pib_pkg::CountW-1:0] color_count;
    logic                       overflow_seen;
  } code_beat_t;

  class palette_tracker;
    logic [pib_pkg::ColorW-1:0] colors [MaxColors];
    int unsigned                n_colors;
    bit                         overflow;
    code_beat_t                 pending_codes [$];
    int unsigned                errors;

    function void note_pixel(logic [pib_pkg::ChanW-1:0] r, logic [pib_pkg::ChanW-1:0] g,
                             logic [pib_pkg::ChanW-1:0] b, logic fs);
      logic [pib_pkg::ColorW-1:0] rgb;
      code_beat_t                 beat;
      int unsigned                k;
      bit                         hit;
      rgb = {r, g, b};
      hit = 1'b0;
      k   = 0;
      if (fs) begin
        n_colors = 0;
        overflow = 1'b0;
      end
      while (!hit && k < n_colors) begin
        if (colors[k] == rgb) hit = 1'b1;
        else k++;
      end
      if (hit) begin
        beat.pixel_code = pib_pkg::CodeOffset + pib_pkg::CountW'(k);
        beat.status     = pib_pkg::StatusFound;
      end else if (n_colors < MaxColors) begin
        colors[n_colors] = rgb;
        beat.pixel_code  = pib_pkg::CodeOffset + pib_pkg::CountW'(n_colors);
        beat.status      = pib_pkg::StatusAdded;
        n_colors++;
      end else begin
        beat.pixel_code = pib_pkg::CodeFull;
        beat.status     = pib_pkg::StatusFull;
        overflow        = 1'b1;
      end
      beat.color_count   = pib_pkg::CountW'(n_colors);
      beat.overflow_seen = overflow;
      pending_codes.push_back(beat);
    endfunction

    function void compare(string field, logic [pib_pkg::CountW-1:0] want,
                          logic [pib_pkg::CountW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_code(code_beat_t got);
      code_beat_t want;
      if (pending_codes.size() == 0) begin
        errors++;
        $display("%0t: code beat with none expected, expected none, actual %p", $time, got);
        return;
      end
      want = pending_codes.pop_front();
      compare("pixel_code", want.pixel_code, got.pixel_code);
      compare("status", pib_pkg::CountW'(want.status), pib_pkg::CountW'(got.status));
      compare("color_count", want.color_count, got.color_count);
      compare("overflow_seen", pib_pkg::CountW'(want.overflow_seen),
              pib_pkg::CountW'(got.overflow_seen));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pib_pixel_if pixel_bus ();
  pib_code_if  code_bus ();

  palette_index_builder_unit #(
    .MAX_COLORS (MaxColors)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pixel_bus),
    .code_o  (code_bus)
  );

  palette_tracker tracker = new;
  int unsigned    idle_cycles;
  int unsigned    pixels_sent;
  bit             src_calm;
  bit             snk_calm;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(ref bit calm);
    if ($urandom_range(0, 40) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  task automatic send_pixel(input logic [pib_pkg::ColorW-1:0] rgb, input logic fs);
    int unsigned gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pixel_bus.valid       <= 1'b1;
    pixel_bus.red         <= rgb[23:16];
    pixel_bus.green       <= rgb[15:8];
    pixel_bus.blue        <= rgb[7:0];
    pixel_bus.frame_start <= fs;
    do @(posedge clk_i); while (!(pixel_bus.valid && pixel_bus.ready));
    pixels_sent++;
  endtask

  task automatic hold_until_drained();
    pixel_bus.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_codes.size() != 0);
  endtask

  task automatic run_pool_frame();
    logic [pib_pkg::ColorW-1:0] pool [$];
    int unsigned                len;
    int unsigned                n;
    logic                       fs;
    n   = $urandom_range(1, 32);
    len = $urandom_range(4, 64);
    repeat (n) pool.push_back(pib_pkg::ColorW'($urandom()));
    fs = ($urandom_range(0, 4) != 0);
    for (int unsigned i = 0; i < len; i++) begin
      send_pixel(pool[$urandom_range(0, n - 1)], (i == 0) ? fs : 1'b0);
    end
  endtask

  task automatic run_fill_frame();
    logic [pib_pkg::ColorW-1:0] seen [$];
    logic [pib_pkg::ColorW-1:0] rgb;
    logic [pib_pkg::ChanW-1:0]  salt;
    int unsigned                extra;
    salt = pib_pkg::ChanW'($urandom());
    for (int unsigned k = 0; k < MaxColors; k++) begin
      if (seen.size() != 0 && $urandom_range(0, 7) == 0) begin
        send_pixel(seen[$urandom_range(0, seen.size() - 1)], 1'b0);
      end
      rgb = {pib_pkg::ChanW'(k) ^ salt, 16'($urandom())};
      seen.push_back(rgb);
      send_pixel(rgb, (k == 0));
    end
    extra = $urandom_range(30, 60);
    repeat (extra) begin
      if ($urandom_range(0, 1) == 0) send_pixel(pib_pkg::ColorW'($urandom()), 1'b0);
      else send_pixel(seen[$urandom_range(0, seen.size() - 1)], 1'b0);
    end
  endtask

  task automatic run_noise(input int unsigned len);
    repeat (len) send_pixel(pib_pkg::ColorW'($urandom()), ($urandom_range(0, 15) == 0));
  endtask

  initial begin
    int unsigned frames;
    rst_ni                <= 1'b0;
    pixel_bus.valid       <= 1'b0;
    pixel_bus.red         <= '0;
    pixel_bus.green       <= '0;
    pixel_bus.blue        <= '0;
    pixel_bus.frame_start <= 1'b0;
    code_bus.ready        <= 1'b0;
    pixels_sent = 0;
    frames      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hffffff, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hff0000, 1'b0);
    send_pixel(24'h00ff00, 1'b0);
    send_pixel(24'h0000ff, 1'b0);
    send_pixel(24'haa55aa, 1'b0);
    send_pixel(24'h55aa55, 1'b0);
    send_pixel(24'hffffff, 1'b0);
    send_pixel(24'hffffff, 1'b1);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hffffff, 1'b0);
    hold_until_drained();

    while (pixels_sent < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) hold_until_drained();
      if (frames % 6 == 1) run_fill_frame();
      else if ($urandom_range(0, 3) == 0) run_noise($urandom_range(1, 20));
      else run_pool_frame();
      frames++;
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_codes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    snk_calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap(snk_calm);
      if (stall > 0) begin
        code_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      code_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(code_bus.valid && code_bus.ready));
    end
  end

  always @(posedge clk_i) begin
    code_beat_t got;
    if (rst_ni) begin
      if (pixel_bus.valid && pixel_bus.ready) begin
        tracker.note_pixel(pixel_bus.red, pixel_bus.green, pixel_bus.blue,
                           pixel_bus.frame_start);
      end
      if (code_bus.valid && code_bus.ready) begin
        got.pixel_code    = code_bus.pixel_code;
        got.status        = code_bus.status;
        got.color_count   = code_bus.color_count;
        got.overflow_seen = code_bus.overflow_seen;
        tracker.check_code(got);
      end
      if ((pixel_bus.valid && pixel_bus.ready) || (code_bus.valid && code_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("%0t: no beat for %0d cycles", $time, idle_cycles);
          $display("tb: failure");
          $finish;
        end
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pib_pkg.sv
hw/rtl/pib_pixel_if.sv
hw/rtl/pib_code_if.sv
hw/rtl/pib_ram.sv
hw/rtl/pib_ctrl.sv
hw/rtl/pib_datapath.sv
hw/rtl/palette_index_builder_unit.sv
hw/rtl/pib_checker.sv
verif/tb_palette_index_builder_unit.sv
